// ===== hdl/lateral_hold_velocity_mixer_top_defines.svh =====
`ifndef LATERAL_HOLD_VELOCITY_MIXER_TOP_DEFINES_SVH
`define LATERAL_HOLD_VELOCITY_MIXER_TOP_DEFINES_SVH
// Assertion helpers: a plain implication and a next-cycle implication.
`define LHVM_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m: check failed");
`define LHVM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("%m: check failed");
`endif

// ===== hdl/lhvm_pkg.sv =====
package lhvm_pkg;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int VW = 48;
   localparam int ZW = 32;
   localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd589824000;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
   localparam logic [12:0] SPEED_MAX = 13'd8191;
   localparam logic [9:0] SLOW_ERR_MM = 10'd500;
   localparam logic [1:0] REG_SIDE = 2'd0;
   localparam logic [1:0] REG_DEAD = 2'd1;
   localparam logic [1:0] REG_MAXADJ = 2'd2;
   localparam logic [1:0] REG_MINSPD = 2'd3;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
      logic signed [13:0]   corr;
      logic                 aligned;
      logic [11:0]          min_spd;
   } stage_type;

   function automatic logic signed [ZW-1:0] atan_of(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = 32'sd294912000;  1: r = 32'sd174096719; 2: r = 32'sd91987925;
         3: r = 32'sd46694507;   4: r = 32'sd23437865;  5: r = 32'sd11730358;
         6: r = 32'sd5866610;    7: r = 32'sd2933484;   8: r = 32'sd1466764;
         9: r = 32'sd733385;     10: r = 32'sd366693;   11: r = 32'sd183346;
         12: r = 32'sd91673;     13: r = 32'sd45837;    14: r = 32'sd22918;
         15: r = 32'sd11459;     16: r = 32'sd5730;     17: r = 32'sd2865;
         18: r = 32'sd1432;      19: r = 32'sd716;      20: r = 32'sd358;
         21: r = 32'sd179;       22: r = 32'sd90;       23: r = 32'sd45;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ===== hdl/lhvm_req_if.sv =====
interface lhvm_req_if;
   logic               valid;
   logic               ready;
   logic [12:0]        target_offset_mm;
   logic signed [15:0] heading_centideg;
   logic [11:0]        base_speed;
   logic [12:0]        sensor_a_mm;
   logic [12:0]        sensor_b_mm;
   modport source (output valid, target_offset_mm, heading_centideg, base_speed,
                   sensor_a_mm, sensor_b_mm, input ready);
   modport sink (input valid, target_offset_mm, heading_centideg, base_speed,
                 sensor_a_mm, sensor_b_mm, output ready);
endinterface

// ===== hdl/lhvm_rsp_if.sv =====
interface lhvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_heading_centideg;
   logic [12:0]        out_speed;
   logic               aligned;
   modport source (output valid, out_heading_centideg, out_speed, aligned, input ready);
   modport sink (input valid, out_heading_centideg, out_speed, aligned, output ready);
endinterface

// ===== hdl/lateral_hold_velocity_mixer_top.sv =====
// The mixer takes one request per clock while no response is held;
// every stage moves together, so a held response stalls the whole
// pipeline, and the two CORDIC chains do one micro-rotation per stage.
`include "lateral_hold_velocity_mixer_top_defines.svh"
module lateral_hold_velocity_mixer_top
   import lhvm_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lhvm_req_if.sink    req,
   lhvm_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int DEPTH = 2 * N + 5;

   logic        side_ff;
   logic [7:0]  dead_ff;
   logic [11:0] maxadj_ff;
   logic [11:0] minspd_ff;
   logic        wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= 1'b0;
         dead_ff   <= 8'd2;
         maxadj_ff <= 12'd500;
         minspd_ff <= 12'd200;
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[3:2])
            REG_SIDE:   side_ff   <= csr_pwdata[0];
            REG_DEAD:   dead_ff   <= csr_pwdata[7:0];
            REG_MAXADJ: maxadj_ff <= csr_pwdata[11:0];
            REG_MINSPD: minspd_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SIDE:   csr_prdata = {31'd0, side_ff};
         REG_DEAD:   csr_prdata = {24'd0, dead_ff};
         REG_MAXADJ: csr_prdata = {20'd0, maxadj_ff};
         REG_MINSPD: csr_prdata = {20'd0, minspd_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Pipeline control: all stages advance together.
   logic [DEPTH-1:0] vld_ff;
   logic             en;
   assign en = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
      end
   end

   // Stage 0: error, correction and heading wrap.
   logic signed [14:0] err;
   logic [13:0]        aerr;
   logic [14:0]        c5;
   logic [11:0]        corr_mag;
   logic               algn;
   logic signed [16:0] hd;
   stage_type          s0_in;
   stage_type          s0_ff;

   always_comb begin
      err = side_ff ? ($signed({2'b0, req.target_offset_mm}) - $signed({2'b0, req.sensor_a_mm}))
                    : ($signed({2'b0, req.sensor_b_mm}) - $signed({2'b0, req.target_offset_mm}));
      aerr = err[14] ? 14'(-err) : 14'(err);
      algn = aerr <= {6'd0, dead_ff};
      c5 = 15'((({5'd0, aerr[9:0]} * 15'd5) + 15'd1) >> 1);
      if (aerr >= {4'd0, SLOW_ERR_MM} || c5 > {3'd0, maxadj_ff}) corr_mag = maxadj_ff;
      else corr_mag = c5[11:0];
      hd = 17'(req.heading_centideg);
      if (hd > 17'sd18000) hd = hd - 17'sd36000;
      else if (hd < -17'sd18000) hd = hd + 17'sd36000;
      s0_in = '0;
      s0_in.x = VW'(28'(req.base_speed) * 28'(INV_GAIN_Q16));
      s0_in.z = ZW'({hd, 16'd0});
      s0_in.corr = algn ? 14'sd0 : (err[14] ? -$signed({2'b0, corr_mag}) : $signed({2'b0, corr_mag}));
      s0_in.aligned = algn;
      s0_in.min_spd = minspd_ff;
   end

   always_ff @(posedge clock) begin
      if (en) s0_ff <= s0_in;
   end

   // Stage 1: quadrant pre-rotation.
   stage_type s1_in;
   stage_type s1_ff;
   always_comb begin
      s1_in = s0_ff;
      if (s0_ff.z > QUARTER_TURN) begin
         s1_in.y = s0_ff.x; s1_in.x = '0; s1_in.z = s0_ff.z - QUARTER_TURN;
      end else if (s0_ff.z < -QUARTER_TURN) begin
         s1_in.y = -s0_ff.x; s1_in.x = '0; s1_in.z = s0_ff.z + QUARTER_TURN;
      end
   end
   always_ff @(posedge clock) begin
      if (en) s1_ff <= s1_in;
   end

   stage_type rot [N+1];
   assign rot[0] = s1_ff;
   for (genvar i = 0; i < N; i++) begin : g_rot
      lhvm_cordic_stage #(.IDX(i), .VECTOR(1'b0), .ACTIVE(1'b1)) u_st (
         .clock(clock), .en(en), .d(rot[i]), .q(rot[i+1]));
   end

   // Stages: subtract correction from y, then quadrant fold for vectoring.
   function automatic logic signed [VW-17:0] s0_pad(input logic signed [13:0] c);
      return (VW-16)'(c);
   endfunction
   stage_type s2_in;
   stage_type s2_ff;
   always_comb begin
      s2_in = rot[N];
      s2_in.y = rot[N].y - VW'({s0_pad(rot[N].corr), 16'd0});
      s2_in.z = '0;
   end
   always_ff @(posedge clock) begin
      if (en) s2_ff <= s2_in;
   end

   stage_type s3_in;
   stage_type s3_ff;
   always_comb begin
      s3_in = s2_ff;
      s3_in.zero = (s2_ff.x == '0) && (s2_ff.y == '0);
      if (s2_ff.x < 0) begin
         if (s2_ff.y >= 0) begin
            s3_in.x = s2_ff.y; s3_in.y = -s2_ff.x; s3_in.z = QUARTER_TURN;
         end else begin
            s3_in.x = -s2_ff.y; s3_in.y = s2_ff.x; s3_in.z = -QUARTER_TURN;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) s3_ff <= s3_in;
   end

   stage_type vec [N+1];
   assign vec[0] = s3_ff;
   for (genvar i = 0; i < N; i++) begin : g_vec
      lhvm_cordic_stage #(.IDX(i), .VECTOR(1'b1), .ACTIVE(1'b1)) u_st (
         .clock(clock), .en(en), .d(vec[i]), .q(vec[i+1]));
   end

   // Rounding, gain compensation and limits.
   stage_type          fv;
   logic signed [ZW-1:0] az;
   logic [ZW-17:0]     hq;
   logic signed [16:0] hs;
   logic [VW-1:0]      xp;
   logic [VW+15:0]     prod;
   logic [31:0]        magw;
   logic [12:0]        mag;
   logic signed [15:0] head_in;
   logic [12:0]        spd_in;
   logic signed [15:0] head_ff;
   logic [12:0]        spd_ff;
   logic               alg_ff;

   always_comb begin
      fv = vec[N];
      az = fv.z[ZW-1] ? -fv.z : fv.z;
      hq = (ZW-16)'((az + 32'sd32768) >>> 16);
      hs = fv.z[ZW-1] ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
      if (hs > 17'sd18000) hs = 17'sd18000;
      if (hs < -17'sd18000) hs = -17'sd18000;
      xp = fv.x[VW-1] ? '0 : fv.x;
      prod = {16'd0, xp} * {{VW{1'b0}}, INV_GAIN_Q16};
      magw = 32'((prod + 64'h80000000) >> 32);
      mag = (magw > 32'(SPEED_MAX)) ? SPEED_MAX : magw[12:0];
      if (fv.zero) begin
         head_in = '0;
         mag = '0;
      end else begin
         head_in = hs[15:0];
      end
      if (mag < {1'b0, fv.min_spd}) mag = {1'b0, fv.min_spd};
      spd_in = mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff <= head_in;
         spd_ff  <= spd_in;
         alg_ff  <= fv.aligned;
      end
   end

   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.out_heading_centideg = head_ff;
   assign rsp.out_speed = spd_ff;
   assign rsp.aligned = alg_ff;

   `LHVM_ASSERT_IMP(a_stall_ready, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   `LHVM_ASSERT_NEXT(a_hold_out, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.out_speed))
   `LHVM_ASSERT_IMP(a_speed_range, clock, reset, rsp.valid, rsp.out_speed <= SPEED_MAX)
endmodule

// ===== hdl/lhvm_cordic_stage.sv =====
module lhvm_cordic_stage
   import lhvm_pkg::*;
#(
   parameter int IDX = 0,
   parameter bit VECTOR = 1'b0,
   parameter bit ACTIVE = 1'b1
) (
   input  logic      clock,
   input  logic      en,
   input  stage_type d,
   output stage_type q
);
   stage_type q_in;
   stage_type q_ff;
   logic signed [VW-1:0] dx;
   logic signed [VW-1:0] dy;
   logic                 up;

   always_comb begin
      dx = d.y >>> IDX;
      dy = d.x >>> IDX;
      up = VECTOR ? (d.y < 0) : (d.z >= 0);
      q_in = d;
      if (ACTIVE) begin
         if (VECTOR ? !up : up) begin
            q_in.x = VECTOR ? d.x + dx : d.x - dx;
            q_in.y = VECTOR ? d.y - dy : d.y + dy;
            q_in.z = VECTOR ? d.z + atan_of(IDX) : d.z - atan_of(IDX);
         end else begin
            q_in.x = VECTOR ? d.x - dx : d.x + dx;
            q_in.y = VECTOR ? d.y + dy : d.y - dy;
            q_in.z = VECTOR ? d.z - atan_of(IDX) : d.z + atan_of(IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end
   assign q = q_ff;
endmodule

// ===== sim/lhvm_tb_pkg.sv =====
`timescale 1ns / 1ps
package lhvm_tb_pkg;
   import lhvm_pkg::*;

   typedef struct {
      logic [12:0]        target;
      logic signed [15:0] heading;
      logic [11:0]        speed;
      logic [12:0]        sen_a;
      logic [12:0]        sen_b;
   } drive_cmd_type;

   typedef struct {
      logic signed [15:0] heading;
      logic [12:0]        speed;
      logic               aligned;
   } drive_out_type;

   class mixer_scoreboard;
      bit              side_sel;
      int unsigned     deadzone;
      int unsigned     max_adj;
      int unsigned     min_spd;
      drive_out_type   pending[$];
      int              errors;

      function new();
         side_sel = 0;
         deadzone = 2;
         max_adj = 500;
         min_spd = 200;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, int unsigned v);
         case (idx)
            REG_SIDE:   side_sel = v[0];
            REG_DEAD:   deadzone = v & 32'hFF;
            REG_MAXADJ: max_adj = v & 32'hFFF;
            REG_MINSPD: min_spd = v & 32'hFFF;
            default: ;
         endcase
      endfunction

      static function longint fshr(longint v, int s);
         return v >>> s;
      endfunction

      static function longint atan_step(int i);
         longint t[24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
            5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918,
            11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
         return t[i];
      endfunction

      function drive_out_type mix(drive_cmd_type c, int steps);
         longint hd, err, aerr, corr, x, y, z, t, dx, dy, hout;
         longint unsigned mag;
         bit al;
         drive_out_type r;
         hd = c.heading;
         if (hd > 18000) hd -= 36000;
         else if (hd < -18000) hd += 36000;
         err = side_sel ? longint'(c.target) - longint'(c.sen_a)
                        : longint'(c.sen_b) - longint'(c.target);
         aerr = err < 0 ? -err : err;
         al = aerr <= deadzone;
         corr = 0;
         if (!al) begin
            if (aerr >= 500) corr = max_adj;
            else begin
               corr = (5 * aerr + 1) >>> 1;
               if (corr > max_adj) corr = max_adj;
            end
            if (err < 0) corr = -corr;
         end
         x = longint'(c.speed) * 39797;
         y = 0;
         z = hd * 65536;
         if (z > 589824000) begin
            y = x; x = 0; z -= 589824000;
         end else if (z < -589824000) begin
            y = -x; x = 0; z += 589824000;
         end
         for (int i = 0; i < steps; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step(i);
            end else begin
               x += dx; y -= dy; z += atan_step(i);
            end
         end
         y -= corr * 65536;
         if (x == 0 && y == 0) begin
            hout = 0;
            mag = 0;
         end else begin
            z = 0;
            if (x < 0) begin
               if (y >= 0) begin
                  t = x; x = y; y = -t; z = 589824000;
               end else begin
                  t = x; x = -y; y = t; z = -589824000;
               end
            end
            for (int i = 0; i < steps; i++) begin
               dx = fshr(y, i);
               dy = fshr(x, i);
               if (y >= 0) begin
                  x += dx; y -= dy; z += atan_step(i);
               end else begin
                  x -= dx; y += dy; z -= atan_step(i);
               end
            end
            hout = z >= 0 ? (z + 32768) >>> 16 : -((-z + 32768) >>> 16);
            if (hout > 18000) hout = 18000;
            if (hout < -18000) hout = -18000;
            if (x < 0) x = 0;
            mag = (longint'(x) * 39797 + 64'd2147483648) >> 32;
         end
         if (mag < min_spd) mag = min_spd;
         if (mag > 8191) mag = 8191;
         r.heading = hout[15:0];
         r.speed = mag[12:0];
         r.aligned = al;
         return r;
      endfunction

      function void note_request(drive_cmd_type c, int steps);
         pending.push_back(mix(c, steps));
      endfunction

      function void check_result(drive_out_type a);
         drive_out_type e;
         if (pending.size() == 0) begin
            $error("unexpected result: heading %0d speed %0d", a.heading, a.speed);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.heading !== e.heading) begin
            $error("out_heading_centideg: expected %0d, actual %0d", e.heading, a.heading);
            errors++;
         end
         if (a.speed !== e.speed) begin
            $error("out_speed: expected %0d, actual %0d", e.speed, a.speed);
            errors++;
         end
         if (a.aligned !== e.aligned) begin
            $error("aligned: expected %0d, actual %0d", e.aligned, a.aligned);
            errors++;
         end
      endfunction
   endclass
endpackage

// ===== sim/lateral_hold_velocity_mixer_top_tb.sv =====
`timescale 1ns / 1ps
module lateral_hold_velocity_mixer_top_tb;
   import lhvm_pkg::*;
   import lhvm_tb_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEF;
   localparam int LATENCY = STEPS * 2 + 5;
   localparam longint LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          calm;
   longint      cycles;
   mixer_scoreboard board;

   lhvm_req_if req ();
   lhvm_rsp_if rsp ();

   lateral_hold_velocity_mixer_top #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      drive_out_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.heading = rsp.out_heading_centideg;
         got.speed = rsp.out_speed;
         got.aligned = rsp.aligned;
         board.check_result(got);
      end
   end

   initial begin
      rsp.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp.ready <= 1;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] v);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send(drive_cmd_type c);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req.valid <= 1;
      req.target_offset_mm <= c.target;
      req.heading_centideg <= c.heading;
      req.base_speed <= c.speed;
      req.sensor_a_mm <= c.sen_a;
      req.sensor_b_mm <= c.sen_b;
      do @(posedge clock); while (!req.ready);
      board.note_request(c, STEPS);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic drive_cmd_type rand_cmd();
      drive_cmd_type c;
      int e;
      c.target = $urandom_range(0, 8191);
      c.heading = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                              : 16'($urandom_range(0, 36000) - 18000);
      c.speed = $urandom_range(0, 4095);
      c.sen_a = $urandom_range(0, 8191);
      c.sen_b = $urandom_range(0, 8191);
      if ($urandom_range(0, 1)) begin
         e = $urandom_range(0, 700) - 350;
         c.sen_a = 13'(int'(c.target) - e);
         c.sen_b = 13'(int'(c.target) + e);
      end
      return c;
   endfunction

   initial begin
      drive_cmd_type c;
      drive_cmd_type dir[$];
      int settings[5][4] = '{'{0, 2, 500, 200}, '{1, 0, 0, 0}, '{1, 255, 4095, 4095},
                             '{0, 17, 123, 0}, '{1, 5, 2000, 50}};
      board = new();
      calm = 0;
      reset = 1;
      req.valid = 0;
      req.target_offset_mm = 0;
      req.heading_centideg = 0;
      req.base_speed = 0;
      req.sensor_a_mm = 0;
      req.sensor_b_mm = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir.push_back('{0, 0, 0, 0, 0});
      dir.push_back('{8191, 18000, 4095, 8191, 8191});
      dir.push_back('{8191, -18000, 4095, 0, 0});
      dir.push_back('{100, 16'sh7FFF, 1000, 100, 100});
      dir.push_back('{100, 16'sh8000, 1000, 50, 150});
      dir.push_back('{1000, 9000, 300, 1001, 999});
      dir.push_back('{1000, -9000, 300, 1002, 998});
      dir.push_back('{1000, 0, 0, 1500, 500});
      dir.push_back('{1000, 0, 100, 500, 1500});
      dir.push_back('{4000, 4500, 2000, 0, 8191});
      dir.push_back('{500, 0, 200, 500, 580});
      dir.push_back('{500, 18001, 600, 400, 300});
      dir.push_back('{500, -18001, 600, 600, 700});
      dir.push_back('{0, 17999, 4095, 8191, 0});
      for (int s = 0; s < 5; s++) begin
         for (int r = 0; r < 4; r++) write_reg(r[1:0], settings[s][r]);
         foreach (dir[i]) send(dir[i]);
         for (int k = 0; k < 90; k++) begin
            if (s == 4 && k == 40) calm = 1;
            send(rand_cmd());
         end
         drain();
      end
      write_reg(2'd3, 32'hFFFF_F0C8);
      write_reg(2'd1, 32'h0000_0303);
      for (int k = 0; k < 20; k++) send(rand_cmd());
      drain();
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
